/* rtl/ple_pkg.sv */
// shared widths, operation and status codes for the positional list engine
// no dependencies; imported by positional_list_engine_core
package ple_pkg;

    localparam int DEFAULT_CAPACITY = 256;

    localparam int KIND_W = 2;
    localparam int POS_W  = 9;
    localparam int VAL_W  = 32;
    localparam int ST_W   = 2;
    localparam int LEN_W  = 9;

    // payload words rounded up to whole bytes
    localparam int IN_TDATA_W  = ((POS_W + VAL_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((VAL_W + LEN_W + 7) / 8) * 8;

    localparam logic [KIND_W-1:0] KIND_GET = 2'd0;
    localparam logic [KIND_W-1:0] KIND_INS = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DEL = 2'd2;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

endpackage

/* rtl/positional_list_engine_core.sv */
// positional list engine: ordered list of signed 32-bit values in one memory
// depends on ple_pkg (widths, operation and status codes)
//
// usage
// - request channel s_*: s_tuser carries the operation (get, insert before
//   position, delete at position), s_tdata carries position and value
// - result channel m_*: m_tuser carries the status, m_tdata carries the
//   value read by a get and the list length after the request
// - one result transaction per request transaction, in request order
// - the element memory has one read and one write port: every element
//   shifted by an insert or delete is one read and one write-back,
//   pipelined one element per cycle
// - one request is worked on at a time; s_tready is high only while idle
// - the result sits in an output register, so a new request is taken while
//   the previous result still waits for m_tready; a stalled result holds
//   and only blocks completion of the following request
// - reset empties the list at once (length zero); the memory is not cleared
//   because positions beyond the length are never read
module positional_list_engine_core #(
    parameter int CAPACITY = ple_pkg::DEFAULT_CAPACITY
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [8:0] position, [40:9] value, upper bits zero
    input  logic [ple_pkg::IN_TDATA_W-1:0] s_tdata,
    // [1:0] kind
    input  logic [ple_pkg::KIND_W-1:0]     s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [31:0] read_value, [40:32] list_length, upper bits zero
    output logic [ple_pkg::OUT_TDATA_W-1:0] m_tdata,
    // [1:0] status
    output logic [ple_pkg::ST_W-1:0]       m_tuser
);
    import ple_pkg::*;

    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int ADDR_W = $clog2(CAPACITY);
    // compare width wide enough for position, length and length+1
    localparam int CMP_W  = (CNT_W + 1 > POS_W) ? CNT_W + 1 : POS_W;
    localparam int PAD_W  = OUT_TDATA_W - VAL_W - LEN_W;

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_GET   = 3'd1;
    localparam logic [2:0] S_SHIFT = 3'd2;
    localparam logic [2:0] S_WRV   = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    // element memory, one write and one registered read per cycle
    logic [VAL_W-1:0]  mem [CAPACITY];
    logic [VAL_W-1:0]  rdata_reg;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [ADDR_W-1:0] mem_raddr;
    logic [VAL_W-1:0]  mem_wdata;

    // control state
    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             issue_reg, issue_next;     // shift reads still to issue
    logic             rdv_reg, rdv_next;         // read data due for write-back
    logic             m_tvalid_reg, m_tvalid_next;

    // working payload
    logic [ADDR_W-1:0] cur_reg, cur_next;        // next address to read
    logic [ADDR_W-1:0] stop_reg, stop_next;      // last address to read
    logic [ADDR_W-1:0] dst_reg, dst_next;        // write-back address
    logic [ADDR_W-1:0] wpos_reg, wpos_next;      // slot for the inserted value
    logic [VAL_W-1:0]  value_reg, value_next;
    logic              is_ins_reg, is_ins_next;
    logic [ST_W-1:0]   res_status_reg, res_status_next;
    logic [VAL_W-1:0]  res_value_reg, res_value_next;
    logic [LEN_W-1:0]  res_len_reg, res_len_next;
    logic [OUT_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [ST_W-1:0]        m_tuser_reg, m_tuser_next;

    // request decode
    logic [POS_W-1:0]  in_pos;
    logic [VAL_W-1:0]  in_value;
    logic [CMP_W-1:0]  pos_e;
    logic [CMP_W-1:0]  cnt_e;
    logic [ADDR_W-1:0] in_pm1;
    logic              pos_nz;
    logic              pos_in_list;               // 1..length
    logic              pos_in_gap;                // 1..length+1
    logic              list_full;

    assign in_pos      = s_tdata[POS_W-1:0];
    assign in_value    = s_tdata[POS_W+VAL_W-1:POS_W];
    assign pos_e       = CMP_W'(in_pos);
    assign cnt_e       = CMP_W'(count_reg);
    assign in_pm1      = ADDR_W'(pos_e - 1'b1);
    assign pos_nz      = (in_pos != '0);
    assign pos_in_list = pos_nz && (pos_e <= cnt_e);
    assign pos_in_gap  = pos_nz && (pos_e <= cnt_e + 1'b1);
    assign list_full   = (count_reg == CNT_W'(CAPACITY));

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        issue_next      = issue_reg;
        rdv_next        = rdv_reg;
        cur_next        = cur_reg;
        stop_next       = stop_reg;
        dst_next        = dst_reg;
        wpos_next       = wpos_reg;
        value_next      = value_reg;
        is_ins_next     = is_ins_reg;
        res_status_next = res_status_reg;
        res_value_next  = res_value_reg;
        res_len_next    = res_len_reg;
        m_tdata_next    = m_tdata_reg;
        m_tuser_next    = m_tuser_reg;
        m_tvalid_next   = m_tvalid_reg;

        mem_we    = 1'b0;
        mem_waddr = dst_reg;
        mem_wdata = rdata_reg;
        mem_raddr = cur_reg;

        // result taken downstream
        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                // a get reads its entry straight from the request
                mem_raddr = in_pm1;
                if (s_tvalid)
                begin
                    res_status_next = ST_RANGE;
                    res_value_next  = '0;
                    wpos_next       = in_pm1;
                    value_next      = in_value;
                    state_next      = S_DONE;
                    unique case (s_tuser)
                        KIND_GET:
                        begin
                            if (pos_in_list)
                            begin
                                res_status_next = ST_OK;
                                state_next      = S_GET;
                            end
                        end
                        KIND_INS:
                        begin
                            if (pos_in_gap)
                            begin
                                if (list_full)
                                begin
                                    res_status_next = ST_FULL;
                                end
                                else
                                begin
                                    res_status_next = ST_OK;
                                    count_next      = CNT_W'(count_reg + 1'b1);
                                    is_ins_next     = 1'b1;
                                    if (pos_e == cnt_e + 1'b1)
                                    begin
                                        // append, nothing to move
                                        state_next = S_WRV;
                                    end
                                    else
                                    begin
                                        // move tail up, starting at the last element
                                        cur_next   = ADDR_W'(count_reg - 1'b1);
                                        stop_next  = in_pm1;
                                        issue_next = 1'b1;
                                        rdv_next   = 1'b0;
                                        state_next = S_SHIFT;
                                    end
                                end
                            end
                        end
                        KIND_DEL:
                        begin
                            if (pos_in_list)
                            begin
                                res_status_next = ST_OK;
                                count_next      = CNT_W'(count_reg - 1'b1);
                                is_ins_next     = 1'b0;
                                if (pos_e != cnt_e)
                                begin
                                    // move tail down, starting just past the hole
                                    cur_next   = ADDR_W'(pos_e);
                                    stop_next  = ADDR_W'(count_reg - 1'b1);
                                    issue_next = 1'b1;
                                    rdv_next   = 1'b0;
                                    state_next = S_SHIFT;
                                end
                            end
                        end
                        default:
                        begin
                            // unused code, refused
                        end
                    endcase
                    res_len_next = LEN_W'(count_next);
                end
            end
            S_GET:
            begin
                res_value_next = rdata_reg;
                state_next     = S_DONE;
            end
            S_SHIFT:
            begin
                // write back the element read last cycle
                if (rdv_reg)
                begin
                    mem_we = 1'b1;
                end
                if (issue_reg)
                begin
                    rdv_next = 1'b1;
                    dst_next = is_ins_reg ? ADDR_W'(cur_reg + 1'b1)
                                          : ADDR_W'(cur_reg - 1'b1);
                    if (cur_reg == stop_reg)
                    begin
                        issue_next = 1'b0;
                    end
                    else
                    begin
                        cur_next = is_ins_reg ? ADDR_W'(cur_reg - 1'b1)
                                              : ADDR_W'(cur_reg + 1'b1);
                    end
                end
                else
                begin
                    rdv_next   = 1'b0;
                    state_next = is_ins_reg ? S_WRV : S_DONE;
                end
            end
            S_WRV:
            begin
                mem_we     = 1'b1;
                mem_waddr  = wpos_reg;
                mem_wdata  = value_reg;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                // output register free or being emptied this cycle
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {{PAD_W{1'b0}}, res_len_reg, res_value_reg};
                    m_tuser_next  = res_status_reg;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // element memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_raddr];
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            issue_reg    <= 1'b0;
            rdv_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            issue_reg    <= issue_next;
            rdv_reg      <= rdv_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cur_reg        <= cur_next;
        stop_reg       <= stop_next;
        dst_reg        <= dst_next;
        wpos_reg       <= wpos_next;
        value_reg      <= value_next;
        is_ins_reg     <= is_ins_next;
        res_status_reg <= res_status_next;
        res_value_reg  <= res_value_next;
        res_len_reg    <= res_len_next;
        m_tdata_reg    <= m_tdata_next;
        m_tuser_reg    <= m_tuser_next;
    end

endmodule
